/* sv/tlr_pkg.sv */
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared types and constants for the telnet line receiver: event codes,
// telnet command bytes and the parser result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tlr_pkg;

    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 10;
    localparam int LEN_W   = 10;
    localparam int EVENT_W = 3;

    // telnet command bytes
    localparam logic [BYTE_W-1:0] B_IAC  = 8'hFF;
    localparam logic [BYTE_W-1:0] B_DONT = 8'hFE;
    localparam logic [BYTE_W-1:0] B_DO   = 8'hFD;
    localparam logic [BYTE_W-1:0] B_WONT = 8'hFC;
    localparam logic [BYTE_W-1:0] B_WILL = 8'hFB;
    localparam logic [BYTE_W-1:0] B_EL   = 8'hF8;
    localparam logic [BYTE_W-1:0] B_AYT  = 8'hF6;
    localparam logic [BYTE_W-1:0] B_IP   = 8'hF4;

    // option codes and control characters
    localparam logic [BYTE_W-1:0] OPT_TM  = 8'h06;
    localparam logic [BYTE_W-1:0] OPT_SGA = 8'h03;
    localparam logic [BYTE_W-1:0] CH_BS   = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

    // printable range kept in the line
    localparam logic [BYTE_W-1:0] STORE_LO = 8'h20;
    localparam logic [BYTE_W-1:0] STORE_HI = 8'hFF - 8'h20;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_LINE     = 3'd1,
        EV_LOGOUT   = 3'd2,
        EV_WILL_TM  = 3'd3,
        EV_WILL_SGA = 3'd4,
        EV_AYT      = 3'd5,
        EV_READ     = 3'd6
    } t_event;

    // per-transaction decode from the parser
    typedef struct packed {
        t_event ev;       // result event
        logic   rd_hit;   // read index falls inside the completed line
        logic   we;       // store the current byte at the fill position
    } t_parse_res;

endpackage

`default_nettype wire

/* sv/tlr_line_mem.sv */
// ----------------------------------------------------------------------------
// tlr_line_mem
// Line buffer: one write port, one registered read port. A read issued in
// the same cycle as a write to the same address returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_line_mem
    import tlr_pkg::*;
#(
    parameter int DEPTH = 1023,
    parameter int AW    = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [BYTE_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [0:DEPTH-1];
    logic [BYTE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_q <= i_wdata;
            end else begin
                r_q <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

/* sv/tlr_parser.sv */
// ----------------------------------------------------------------------------
// tlr_parser
// Telnet command parser and line bookkeeping. Holds the parse phase, the
// fill count of the line being built and the length of the completed line.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_parser
    import tlr_pkg::*;
#(
    parameter int LINE_MAX = 1024,
    parameter int DEPTH    = LINE_MAX - 1,
    parameter int CW       = $clog2(LINE_MAX)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic              i_mode,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [IDX_W-1:0]  i_idx,
    output t_parse_res             o_res,
    output logic      [CW-1:0]     o_len,
    output logic      [CW-1:0]     o_fill
);

    typedef enum logic [1:0] {
        PH_DATA   = 2'd0,
        PH_CMD    = 2'd1,
        PH_SKIP   = 2'd2,
        PH_DO_OPT = 2'd3
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_done, n_done;
    logic [CW-1:0] w_inc;

    assign w_inc = r_fill + CW'(1);

    always_comb begin
        n_phase      = r_phase;
        n_fill       = r_fill;
        n_done       = r_done;
        o_res.ev     = EV_NONE;
        o_res.rd_hit = 1'b0;
        o_res.we     = 1'b0;
        o_len        = '0;
        if (i_step) begin
            if (i_mode) begin
                o_res.ev     = EV_READ;
                o_res.rd_hit = (32'(i_idx) < 32'(r_done)) && (32'(i_idx) < 32'(DEPTH));
            end else begin
                // any received byte closes the read window unless it ends a line
                n_done = '0;
                case (r_phase)
                    PH_DATA: begin
                        if (i_byte == B_IAC) begin
                            n_phase = PH_CMD;
                        end else if (i_byte == CH_LF) begin
                            o_res.ev = EV_LINE;
                            o_len    = r_fill;
                            n_done   = r_fill;
                            n_fill   = '0;
                        end else if (i_byte == CH_BS) begin
                            if (r_fill != '0) begin
                                n_fill = r_fill - CW'(1);
                            end
                        end else if (i_byte inside {[STORE_LO:STORE_HI]}) begin
                            if (r_fill < CW'(DEPTH)) begin
                                o_res.we = 1'b1;
                                n_fill   = w_inc;
                            end
                            // buffer full: the line completes on its own
                            if (w_inc >= CW'(DEPTH)) begin
                                o_res.ev = EV_LINE;
                                o_len    = w_inc;
                                n_done   = w_inc;
                                n_fill   = '0;
                            end
                        end
                    end
                    PH_CMD: begin
                        n_phase = PH_DATA;
                        if (i_byte == B_IP) begin
                            n_fill   = '0;
                            o_res.ev = EV_LOGOUT;
                        end else if (i_byte == B_DO) begin
                            n_phase = PH_DO_OPT;
                        end else if (i_byte == B_WILL || i_byte == B_WONT ||
                                     i_byte == B_DONT) begin
                            n_phase = PH_SKIP;
                        end else if (i_byte == B_AYT) begin
                            o_res.ev = EV_AYT;
                        end else if (i_byte == B_EL) begin
                            n_fill = '0;
                        end
                    end
                    PH_SKIP: begin
                        n_phase = PH_DATA;
                    end
                    PH_DO_OPT: begin
                        n_phase = PH_DATA;
                        if (i_byte == OPT_TM) begin
                            o_res.ev = EV_WILL_TM;
                        end else if (i_byte == OPT_SGA) begin
                            o_res.ev = EV_WILL_SGA;
                        end
                    end
                    default: begin
                        n_phase = PH_DATA;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DATA;
            r_fill  <= '0;
            r_done  <= '0;
        end else begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_done  <= n_done;
        end
    end

    assign o_fill = r_fill;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) < 32'(DEPTH))
        else $error("fill count reached the buffer depth");

    a_done_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_done) <= 32'(DEPTH))
        else $error("completed length beyond buffer depth");

    a_write_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.we |-> (i_step && !i_mode && r_phase == PH_DATA))
        else $error("store write outside a plain data byte");

endmodule

`default_nettype wire

/* sv/telnet_line_receiver.sv */
// ----------------------------------------------------------------------------
// telnet_line_receiver
// Assembles command lines from received bytes, strips telnet sequences and
// reports control events; completed lines can be read back by index.
// ----------------------------------------------------------------------------
// Path: an input transaction reaches its result through the input register, then the
//   result register; the line buffer read is issued at acceptance.
// Throughput: one transaction per cycle while i_stall is low; set by the
//   single parser stage and one line buffer write and read per cycle.
// Reset: synchronous; clears parse phase, fill count, completed length and
//   both valid flags. The line buffer is not cleared and needs no sweep.
`default_nettype none

module telnet_line_receiver
    import tlr_pkg::*;
#(
    parameter int LINE_MAX = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_mode,
    input  wire logic [BYTE_W-1:0]  i_data_byte,
    input  wire logic [IDX_W-1:0]   i_read_index,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [EVENT_W-1:0]      o_event_res,
    output logic [LEN_W-1:0]        o_line_length,
    output logic [BYTE_W-1:0]       o_read_data
);

    localparam int DEPTH = LINE_MAX - 1;
    localparam int CW    = $clog2(LINE_MAX);
    localparam int AW    = $clog2(DEPTH);

    // input stage
    logic              r_v;
    logic              r_mode;
    logic [BYTE_W-1:0] r_byte;
    logic [IDX_W-1:0]  r_idx;

    // result stage
    logic              r_o_v;
    t_event            r_o_event;
    logic [LEN_W-1:0]  r_o_len;
    logic [BYTE_W-1:0] r_o_data;

    logic              w_adv;
    logic              w_acc;
    t_parse_res        w_res;
    logic [CW-1:0]     w_len;
    logic [CW-1:0]     w_fill;
    logic [BYTE_W-1:0] w_mem_q;

    assign w_adv   = r_v && (!r_o_v || !i_stall);
    assign o_stall = r_v && !w_adv;
    assign w_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_acc) begin
            r_v <= 1'b1;
        end else if (w_adv) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mode <= i_mode;
            r_byte <= i_data_byte;
            r_idx  <= i_read_index;
        end
    end

    tlr_parser #(
        .LINE_MAX (LINE_MAX),
        .DEPTH    (DEPTH),
        .CW       (CW)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_mode  (r_mode),
        .i_byte  (r_byte),
        .i_idx   (r_idx),
        .o_res   (w_res),
        .o_len   (w_len),
        .o_fill  (w_fill)
    );

    // read is issued with the incoming transaction; a write landing on the
    // same edge is forwarded by the buffer
    tlr_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_res.we),
        .i_waddr (w_fill[AW-1:0]),
        .i_wdata (r_byte),
        .i_re    (w_acc),
        .i_raddr (AW'(i_read_index)),
        .o_rdata (w_mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_adv) begin
            r_o_v <= 1'b1;
        end else if (!i_stall) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_event <= w_res.ev;
            r_o_len   <= LEN_W'(w_len);
            r_o_data  <= w_res.rd_hit ? w_mem_q : '0;
        end
    end

    assign o_valid       = r_o_v;
    assign o_event_res   = r_o_event;
    assign o_line_length = r_o_len;
    assign o_read_data   = r_o_data;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v |-> !o_stall)
        else $error("stall raised with empty input stage");

    a_read_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_mode) |=> (o_valid && r_o_event == EV_READ))
        else $error("read transaction did not give a read event");

    a_len_only_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_o_event != EV_LINE) |-> (o_line_length == '0))
        else $error("line length without line done event");

    a_data_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_o_event != EV_READ) |-> (o_read_data == '0))
        else $error("read data without read event");

endmodule

`default_nettype wire

/* bench/telnet_line_receiver_tb.sv */
// ----------------------------------------------------------------------------
// telnet_line_receiver_tb
// Self-checking bench for the telnet line receiver. Feeds directed telnet
// sequences, one full-length line and random lines and command mixes.
// Idle gaps and output stalls are varied per phase. Every output
// transaction is checked against a cycle-free model of the parser and the
// line store.
// ----------------------------------------------------------------------------
module telnet_line_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlr_pkg::*;

    localparam int LINE_MAX       = 1024;
    localparam int STORE_DEPTH    = LINE_MAX - 1;
    localparam int MAX_INDEX      = 1022;
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 11;
    localparam int TAIL_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 20;

    typedef enum logic [1:0] {
        PH_DATA = 2'd0,
        PH_CMD  = 2'd1,
        PH_SKIP = 2'd2,
        PH_DO   = 2'd3
    } t_parse_phase;

    typedef struct {
        t_event            ev;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
    } t_line_result;

    class line_scoreboard;
        t_line_result      pending[$];
        logic [BYTE_W-1:0] line_buf[STORE_DEPTH];
        int                fill;
        int                done_len;
        t_parse_phase      phase;
        int                errors;

        function new();
            fill     = 0;
            done_len = 0;
            phase    = PH_DATA;
            errors   = 0;
        endfunction

        // Advance the parser by one accepted transaction and queue its result.
        function void take_input(logic mode, logic [BYTE_W-1:0] b, logic [IDX_W-1:0] idx);
            t_line_result r;
            r = '{ev: EV_NONE, len: '0, data: '0};
            if (mode) begin
                r.ev = EV_READ;
                if (idx < done_len) r.data = line_buf[idx];
            end else begin
                // any byte closes the read window unless it completes a line
                done_len = 0;
                case (phase)
                    PH_DATA: begin
                        if (b == B_IAC) begin
                            phase = PH_CMD;
                        end else if (b == CH_LF) begin
                            r.ev     = EV_LINE;
                            r.len    = LEN_W'(fill);
                            done_len = fill;
                            fill     = 0;
                        end else if (b == CH_BS) begin
                            if (fill > 0) fill--;
                        end else if (b >= STORE_LO && b <= STORE_HI) begin
                            line_buf[fill] = b;
                            fill++;
                            if (fill >= STORE_DEPTH) begin
                                r.ev     = EV_LINE;
                                r.len    = LEN_W'(fill);
                                done_len = fill;
                                fill     = 0;
                            end
                        end
                    end
                    PH_CMD: begin
                        phase = PH_DATA;
                        case (b)
                            B_IP: begin
                                fill = 0;
                                r.ev = EV_LOGOUT;
                            end
                            B_DO:                 phase = PH_DO;
                            B_WILL, B_WONT, B_DONT: phase = PH_SKIP;
                            B_AYT:                r.ev = EV_AYT;
                            B_EL:                 fill = 0;
                            default: ;
                        endcase
                    end
                    PH_SKIP: phase = PH_DATA;
                    default: begin
                        phase = PH_DATA;
                        if (b == OPT_TM) r.ev = EV_WILL_TM;
                        else if (b == OPT_SGA) r.ev = EV_WILL_SGA;
                    end
                endcase
            end
            pending.push_back(r);
        endfunction

        function void check_output(logic [EVENT_W-1:0] ev, logic [LEN_W-1:0] len,
                                   logic [BYTE_W-1:0] data);
            t_line_result want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result: event %0d length %0d data %02h",
                             $time, ev, len, data);
                return;
            end
            want = pending.pop_front();
            if (ev !== want.ev || len !== want.len || data !== want.data) begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: result error: event %0d/%0d length %0d/%0d",
                              " data %02h/%02h (got/want)"},
                             $time, ev, want.ev, len, want.len, data, want.data);
            end
        endfunction
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_stall;
    logic               i_mode       = 1'b0;
    logic [BYTE_W-1:0]  i_data_byte  = '0;
    logic [IDX_W-1:0]   i_read_index = '0;
    logic               o_valid;
    logic               i_stall      = 1'b0;
    logic [EVENT_W-1:0] o_event_res;
    logic [LEN_W-1:0]   o_line_length;
    logic [BYTE_W-1:0]  o_read_data;

    line_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    telnet_line_receiver #(
        .LINE_MAX(LINE_MAX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_data_byte  (i_data_byte),
        .i_read_index (i_read_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_res  (o_event_res),
        .o_line_length(o_line_length),
        .o_read_data  (o_read_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_output(o_event_res, o_line_length, o_read_data);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("telnet_line_receiver: mismatch");
            $finish;
        end
    end

    task automatic send_item(logic mode, logic [BYTE_W-1:0] b, logic [IDX_W-1:0] idx);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_data_byte  <= b;
        i_read_index <= idx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_input(mode, b, idx);
        items_sent++;
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] b);
        send_item(1'b0, b, IDX_W'($urandom_range(0, MAX_INDEX)));
    endtask

    task automatic send_read(int idx);
        send_item(1'b1, BYTE_W'($urandom_range(0, 255)), IDX_W'(idx));
    endtask

    task automatic send_telnet_cmd();
        int                pick;
        logic [BYTE_W-1:0] opt;
        logic [BYTE_W-1:0] skip_cmds[3];
        skip_cmds = '{B_WILL, B_WONT, B_DONT};
        pick = $urandom_range(0, 9);
        opt  = BYTE_W'($urandom_range(0, 255));
        send_byte(B_IAC);
        case (pick)
            0: send_byte(B_IP);
            1: send_byte(B_AYT);
            2: send_byte(B_EL);
            3, 4: begin
                send_byte(B_DO);
                case ($urandom_range(0, 2))
                    0: send_byte(OPT_TM);
                    1: send_byte(OPT_SGA);
                    default: send_byte(opt);
                endcase
            end
            5: begin
                send_byte(skip_cmds[$urandom_range(0, 2)]);
                send_byte(opt);
            end
            6: send_byte(B_IAC);
            7: send_byte(BYTE_W'($urandom_range(8'hF0, 8'hFA)));
            8: ;  // dangling IAC, next byte gets taken as the command
            default: send_byte(opt);
        endcase
    endtask

    task automatic send_line(int max_len);
        int n;
        int r;
        int idx;
        n = $urandom_range(0, max_len);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 75) send_byte(BYTE_W'($urandom_range(STORE_LO, STORE_HI)));
            else if (r < 85) send_byte(CH_BS);
            else if (r < 93) begin
                // dropped control or high bytes
                if ($urandom_range(0, 1)) send_byte(BYTE_W'($urandom_range(8'hE0, 8'hFE)));
                else send_byte(BYTE_W'($urandom_range(8'h0B, 8'h1F)));
            end else send_telnet_cmd();
        end
        send_byte(CH_LF);
        repeat ($urandom_range(0, 4)) begin
            if (sb.done_len > 0 && $urandom_range(0, 4) != 0)
                idx = $urandom_range(0, sb.done_len - 1);
            else
                idx = $urandom_range(0, MAX_INDEX);
            send_read(idx);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(int send_pct, int recv_pct);
        int target;
        int r;
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        target        = items_sent + PHASE_ITEMS;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 45) send_line(12);
            else if (r < 55) send_line(40);
            else if (r < 80) send_telnet_cmd();
            else send_item(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                           IDX_W'($urandom_range(0, MAX_INDEX)));
        end
        // sender holds off until every result is back
        drain_results();
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // store range edges, dropped bytes, backspace
        send_byte(STORE_LO);
        send_byte(STORE_HI);
        send_byte(8'h1F);
        send_byte(8'hE0);
        send_byte(CH_BS);
        send_byte(8'h41);
        send_byte(CH_LF);
        send_read(0);
        send_read(1);
        send_read(MAX_INDEX);
        // window closes on any byte that does not finish a line
        send_byte(8'h00);
        send_read(0);
        // erase line, backspace on empty line, empty line
        send_byte(8'h71);
        send_byte(B_IAC);
        send_byte(B_EL);
        send_byte(CH_BS);
        send_byte(CH_LF);
        // logout clears the partial line
        send_byte(8'h61);
        send_byte(B_IAC);
        send_byte(B_IP);
        send_byte(CH_LF);
        send_byte(B_IAC);
        send_byte(B_DO);
        send_byte(OPT_TM);
        send_byte(B_IAC);
        send_byte(B_DO);
        send_byte(OPT_SGA);
        send_byte(B_IAC);
        send_byte(B_AYT);
        send_byte(B_IAC);
        send_byte(B_WILL);
        send_byte(B_IAC);
        // escaped IAC is ignored
        send_byte(B_IAC);
        send_byte(B_IAC);
        drain_results();

        // line that fills the store completes without a newline
        repeat (STORE_DEPTH) send_byte(BYTE_W'($urandom_range(STORE_LO, STORE_HI)));
        send_read(0);
        send_read(512);
        send_read(MAX_INDEX);
        drain_results();

        run_random(0, 0);
        run_random(88, 0);
        run_random(0, 88);
        run_random(24, 24);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("telnet_line_receiver: match");
        end else begin
            $display("telnet_line_receiver: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
sv/tlr_pkg.sv
sv/tlr_line_mem.sv
sv/tlr_parser.sv
sv/telnet_line_receiver.sv
bench/telnet_line_receiver_tb.sv
